// ===== design/fbse_pkg.sv =====
// Shared types, constants and helpers for the framebuffer scroll engine.
// Depends on nothing; the walker, the top level and the bench import it.
package fbse_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int X_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int Y_W     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WDIM_W  = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W  = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PIX_W   = 32;
  localparam int SHIFT_W = 10;
  localparam int DIM_REG_W = 9;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_READ   = 2'd1,
    REQ_SCROLL = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_FILL   = 2'd2,
    CFG_SPARE  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [ADDR_W-1:0] pix_addr(input logic [X_W-1:0] px,
                                                 input logic [Y_W-1:0] py);
    return ADDR_W'(ADDR_W'(py) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(px);
  endfunction

endpackage

// ===== design/fbse_pixel_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used as the pixel store; depends on nothing.
module fbse_pixel_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 16,
  parameter int DEPTH  = 65536
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/fbse_walker.sv =====
// Sequencer that walks the pixel store for scroll, clear and the reset fill.
// Depends on fbse_pkg for geometry, the memory request struct and addressing.
module fbse_walker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start_scroll,
  input  logic                                  start_clear,
  input  logic signed [fbse_pkg::SHIFT_W-1:0]   dx,
  input  logic signed [fbse_pkg::SHIFT_W-1:0]   dy,
  input  logic        [fbse_pkg::WDIM_W-1:0]    act_w,
  input  logic        [fbse_pkg::HDIM_W-1:0]    act_h,
  input  logic        [fbse_pkg::PIX_W-1:0]     fill_color,
  input  logic        [fbse_pkg::PIX_W-1:0]     rd_data,
  output logic                                  busy,
  output fbse_pkg::mem_req_t                    mem_req
);
  import fbse_pkg::*;

  localparam int CW = ((X_W > Y_W) ? ((X_W > SHIFT_W) ? X_W : SHIFT_W)
                                   : ((Y_W > SHIFT_W) ? Y_W : SHIFT_W)) + 2;

  typedef enum logic [1:0] {ST_IDLE, ST_SCROLL, ST_DRAIN, ST_FILL} state_t;

  state_t                    state_r;
  logic [X_W-1:0]            cur_x_r;
  logic [Y_W-1:0]            cur_y_r;
  logic                      desc_x_r;
  logic                      desc_y_r;
  logic signed [SHIFT_W-1:0] dx_r;
  logic signed [SHIFT_W-1:0] dy_r;
  logic [WDIM_W-1:0]         w_r;
  logic [HDIM_W-1:0]         h_r;
  logic                      wv_r;
  logic [ADDR_W-1:0]         waddr_r;
  logic                      wsrc_ok_r;
  logic [ADDR_W-1:0]         fill_addr_r;
  logic                      fill_zero_r;

  logic signed [CW-1:0]      sx;
  logic signed [CW-1:0]      sy;
  logic                      src_ok;
  logic                      x_last;
  logic                      y_last;
  logic [X_W-1:0]            row_start_x;

  // Source coordinate of the pixel under the cursor, and whether it lies
  // inside the active image.
  always_comb begin
    sx = CW'($signed({1'b0, cur_x_r})) - CW'(dx_r);
    sy = CW'($signed({1'b0, cur_y_r})) - CW'(dy_r);
    src_ok = !sx[CW-1] && !sy[CW-1] &&
             ((CW-1)'(sx) < (CW-1)'(w_r)) && ((CW-1)'(sy) < (CW-1)'(h_r));
    x_last = desc_x_r ? (cur_x_r == '0) : (WDIM_W'(cur_x_r) == w_r - 1'b1);
    y_last = desc_y_r ? (cur_y_r == '0) : (HDIM_W'(cur_y_r) == h_r - 1'b1);
    row_start_x = desc_x_r ? X_W'(w_r - 1'b1) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      fill_addr_r <= '0;
      fill_zero_r <= 1'b1;
      wv_r        <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          wv_r <= 1'b0;
          if (start_scroll && (act_w != '0) && (act_h != '0)) begin
            // Walk against the shift so every source is read before it is
            // overwritten in place.
            desc_x_r <= (dx > 0);
            desc_y_r <= (dy > 0);
            dx_r     <= dx;
            dy_r     <= dy;
            w_r      <= act_w;
            h_r      <= act_h;
            cur_x_r  <= (dx > 0) ? X_W'(act_w - 1'b1) : '0;
            cur_y_r  <= (dy > 0) ? Y_W'(act_h - 1'b1) : '0;
            state_r  <= ST_SCROLL;
          end else if (start_clear) begin
            fill_addr_r <= '0;
            fill_zero_r <= 1'b0;
            state_r     <= ST_FILL;
          end
        end
        ST_SCROLL: begin
          wv_r      <= 1'b1;
          waddr_r   <= pix_addr(cur_x_r, cur_y_r);
          wsrc_ok_r <= src_ok;
          if (x_last) begin
            cur_x_r <= row_start_x;
            cur_y_r <= desc_y_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
            if (y_last) begin
              state_r <= ST_DRAIN;
            end
          end else begin
            cur_x_r <= desc_x_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          wv_r    <= 1'b0;
          state_r <= ST_IDLE;
        end
        ST_FILL: begin
          fill_addr_r <= fill_addr_r + 1'b1;
          if (fill_addr_r == ADDR_W'(DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    mem_req.re    = (state_r == ST_SCROLL) && src_ok;
    mem_req.raddr = pix_addr(X_W'(sx), Y_W'(sy));
    if (state_r == ST_FILL) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = fill_addr_r;
      mem_req.wdata = fill_zero_r ? '0 : fill_color;
    end else begin
      mem_req.we    = wv_r;
      mem_req.waddr = waddr_r;
      mem_req.wdata = wsrc_ok_r ? rd_data : fill_color;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== design/framebuffer_scroll_engine.sv =====
// Pixel reads and writes: one request per cycle while results are taken and no walk runs;
// each result passes the one-entry stage and the output register. Scroll: one pixel per
// cycle on the single read and write port. Clear: writes the fill color to every entry.
// After reset (synchronous, active low) a fill pass writes zero to every entry while
// no request is taken; register writes are.
module framebuffer_scroll_engine (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata from bit 0 up: x[7:0], y[7:0], color[31:0], dx[9:0], dy[9:0], zero pad.
  input  logic [71:0] in_tdata,
  // tuser: req_type[1:0].
  input  logic [1:0]  in_tuser,
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata from bit 0 up: read_color[31:0], status, zero pad.
  output logic [39:0] out_tdata,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);
  import fbse_pkg::*;

  // Configuration registers.
  logic [DIM_REG_W-1:0] image_width_r;
  logic [DIM_REG_W-1:0] image_height_r;
  logic [PIX_W-1:0]     fill_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= DIM_REG_W'(256);
      image_height_r <= DIM_REG_W'(256);
      fill_color_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_WIDTH:  image_width_r  <= cfg_wdata[DIM_REG_W-1:0];
        CFG_HEIGHT: image_height_r <= cfg_wdata[DIM_REG_W-1:0];
        CFG_FILL:   fill_color_r   <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // Active size: dimensions above the store's limits clamp to the limit.
  logic [WDIM_W-1:0] act_w;
  logic [HDIM_W-1:0] act_h;
  assign act_w = (int'(image_width_r) > MAX_WIDTH) ? WDIM_W'(MAX_WIDTH)
                                                   : WDIM_W'(image_width_r);
  assign act_h = (int'(image_height_r) > MAX_HEIGHT) ? HDIM_W'(MAX_HEIGHT)
                                                     : HDIM_W'(image_height_r);

  // Request fields.
  req_t                      req;
  logic [7:0]                req_x;
  logic [7:0]                req_y;
  logic [PIX_W-1:0]          req_color;
  logic signed [SHIFT_W-1:0] req_dx;
  logic signed [SHIFT_W-1:0] req_dy;
  logic                      coord_ok;

  assign req       = req_t'(in_tuser);
  assign req_x     = in_tdata[7:0];
  assign req_y     = in_tdata[15:8];
  assign req_color = in_tdata[47:16];
  assign req_dx    = $signed(in_tdata[57:48]);
  assign req_dy    = $signed(in_tdata[67:58]);
  assign coord_ok  = (WDIM_W'(req_x) < act_w) && (HDIM_W'(req_y) < act_h) &&
                     (int'(req_x) < MAX_WIDTH) && (int'(req_y) < MAX_HEIGHT);

  // Result path: a one-entry stage that waits for the read data, then the
  // output register. The stage can refill in the same cycle it moves on, so
  // pixel requests stream at one per cycle while results are taken and no walk runs.
  logic             s1_valid_r;
  logic             s1_is_read_r;
  logic             s1_status_r;
  logic             s1_move;
  logic             in_fire;
  logic             walk_busy;
  logic             out_valid_r;
  logic [PIX_W-1:0] out_color_r;
  logic             out_status_r;
  logic [PIX_W-1:0] ram_rdata;

  assign s1_move   = !out_valid_r || out_tready;
  assign in_tready = !walk_busy && (!s1_valid_r || s1_move);
  assign in_fire   = in_tvalid && in_tready;

  // Scroll and clear results are constant, so they are queued at acceptance;
  // later requests wait for the walk to finish because the block stays busy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_move) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          out_color_r  <= s1_is_read_r ? ram_rdata : '0;
          out_status_r <= s1_status_r;
        end
      end
      if (in_fire) begin
        s1_valid_r   <= 1'b1;
        s1_is_read_r <= (req == REQ_READ) && coord_ok;
        s1_status_r  <= ((req == REQ_WRITE) || (req == REQ_READ)) && !coord_ok;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_status_r, out_color_r};

  // Store sequencer for scroll, clear and the fill pass after reset.
  mem_req_t walk_req;

  fbse_walker u_walker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_scroll (in_fire && (req == REQ_SCROLL)),
    .start_clear  (in_fire && (req == REQ_CLEAR)),
    .dx           (req_dx),
    .dy           (req_dy),
    .act_w        (act_w),
    .act_h        (act_h),
    .fill_color   (fill_color_r),
    .rd_data      (ram_rdata),
    .busy         (walk_busy),
    .mem_req      (walk_req)
  );

  // The store port belongs to the sequencer while it runs, otherwise to
  // the pixel requests; requests are only taken while the sequencer idles.
  mem_req_t         ram_req;
  logic [ADDR_W-1:0] pix_addr_q;

  assign pix_addr_q = pix_addr(X_W'(req_x), Y_W'(req_y));

  always_comb begin
    ram_req = walk_req;
    if (!walk_busy) begin
      ram_req.we    = walk_req.we || (in_fire && (req == REQ_WRITE) && coord_ok);
      ram_req.re    = in_fire && (req == REQ_READ) && coord_ok;
      ram_req.raddr = pix_addr_q;
      if (!walk_req.we) begin
        ram_req.waddr = pix_addr_q;
        ram_req.wdata = req_color;
      end
    end
  end

  fbse_pixel_ram #(
    .DATA_W (PIX_W),
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

`ifndef ASSERT_OFF
  // A request is never taken while the result stage is full and stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (!s1_valid_r || s1_move))
    else $error("request accepted over a pending result");

  // A clear holds off further requests in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (req == REQ_CLEAR)) |=> (walk_busy && !in_tready))
    else $error("clear did not start the store walk");

  // An error result never carries read data.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[32]) |-> (out_tdata[31:0] == '0))
    else $error("error result with nonzero color");

  // While a read result waits in the stage, the store read data must hold.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_is_read_r && !s1_move) |=> $stable(ram_rdata))
    else $error("read data lost before it was forwarded");
`endif

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for framebuffer_scroll_engine: a directed table of requests and
// register writes, then randomized phases checked against a shadow pixel store.
// Depends on fbse_pkg and the framebuffer_scroll_engine RTL.
module tb_top;
  import fbse_pkg::*;

  // The longest correct quiet stretch is a clear, a full-size scroll or the fill pass
  // after reset; this allows several times that.
  localparam int STALL_LIMIT = 300000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASE_ITEMS = 150;
  localparam int PHASES      = 12;

  // What one request should return, plus its kind for the mismatch message.
  typedef struct {
    logic [31:0] color;
    logic        status;
    req_t        kind;
  } reply_t;

  // One row of the directed table: either a register write or a request. Rows whose
  // answer is obvious carry it typed in; all others are judged by the shadow store.
  typedef struct {
    bit          is_reg;
    cfg_idx_t    reg_idx;
    logic [31:0] reg_val;
    req_t        kind;
    logic [7:0]  px;
    logic [7:0]  py;
    logic [31:0] color;
    logic [9:0]  dx;
    logic [9:0]  dy;
    bit          typed;
    logic [31:0] want_color;
    logic        want_status;
  } plan_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = REQ_WRITE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_addr   = CFG_WIDTH;
  logic [31:0] cfg_wdata  = '0;

  framebuffer_scroll_engine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Shadow copy of the pixel store and the registers. The store starts at zero,
  // which is what the fill pass after reset writes.
  bit [31:0]   shadow_frame   [0:DEPTH-1];
  bit [31:0]   shadow_scratch [0:DEPTH-1];
  bit [8:0]    shadow_width  = 9'd256;
  bit [8:0]    shadow_height = 9'd256;
  bit [31:0]   shadow_fill   = '0;

  reply_t      replies_due[$];
  int unsigned mismatch_count = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  bit          hold_off_pending = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // A dimension register above the store size acts as the store size.
  function automatic int active_span(bit [8:0] dim, int cap);
    return (int'(dim) > cap) ? cap : int'(dim);
  endfunction

  // Idle cycles before the next request on one side; at least a third of the draws are
  // zero so that back-to-back runs stay common.
  function automatic int draw_gap(bit enabled);
    if (!enabled || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  // Mostly inside the active span, sometimes anywhere in the 8-bit range so that
  // out-of-range points and the high coordinate bits are reached.
  function automatic logic [7:0] pick_coord(int span);
    if (span > 0 && $urandom_range(0, 99) < 85) return 8'($urandom_range(0, span - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  // Shifts cluster around the active size, where partial and whole-image fills
  // meet; a quarter take any 10-bit pattern.
  function automatic logic [9:0] pick_shift(int span);
    if ($urandom_range(0, 3) != 0) return 10'(int'($urandom_range(0, 2 * span + 2)) - (span + 1));
    return 10'($urandom);
  endfunction

  // Applies one accepted request to the shadow store and returns its reply.
  task automatic apply_to_shadow(input req_t kind, input logic [7:0] px, input logic [7:0] py,
                                 input logic [31:0] color, input logic [9:0] dx,
                                 input logic [9:0] dy, output reply_t r);
    int aw, ah, sdx, sdy, sx, sy, x, y, i;
    aw = active_span(shadow_width, MAX_WIDTH);
    ah = active_span(shadow_height, MAX_HEIGHT);
    r.color  = '0;
    r.status = 1'b0;
    r.kind   = kind;
    case (kind)
      REQ_WRITE, REQ_READ: begin
        if (int'(px) >= aw || int'(py) >= ah) begin
          r.status = 1'b1;
        end else if (kind == REQ_WRITE) begin
          shadow_frame[int'(px) + int'(py) * MAX_WIDTH] = color;
        end else begin
          r.color = shadow_frame[int'(px) + int'(py) * MAX_WIDTH];
        end
      end
      REQ_SCROLL: begin
        // Only the active window moves; everything outside it is left alone.
        sdx = $signed(dx);
        sdy = $signed(dy);
        for (y = 0; y < ah; y++)
          for (x = 0; x < aw; x++)
            shadow_scratch[x + y * MAX_WIDTH] = shadow_frame[x + y * MAX_WIDTH];
        for (y = 0; y < ah; y++) begin
          for (x = 0; x < aw; x++) begin
            sx = x - sdx;
            sy = y - sdy;
            if (sx >= 0 && sy >= 0 && sx < aw && sy < ah)
              shadow_frame[x + y * MAX_WIDTH] = shadow_scratch[sx + sy * MAX_WIDTH];
            else
              shadow_frame[x + y * MAX_WIDTH] = shadow_fill;
          end
        end
      end
      default: begin
        // A clear covers the whole store, not just the active window.
        for (i = 0; i < DEPTH; i++) shadow_frame[i] = shadow_fill;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("[%0t] mismatch: %s got %h, want %h", $time, what, got, want);
  endtask

  // Offers one request after a random gap and holds it until accepted. The
  // reply is predicted at the accepting edge, so it lines up with request order.
  task automatic send_request(input req_t kind, input logic [7:0] px, input logic [7:0] py,
                              input logic [31:0] color, input logic [9:0] dx,
                              input logic [9:0] dy, input bit typed,
                              input logic [31:0] want_color, input logic want_status);
    int gap;
    reply_t r;
    gap = draw_gap(tx_idle_on);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, dy, dx, color, py, px};
    do @(posedge clk); while (in_tready !== 1'b1);
    apply_to_shadow(kind, px, py, color, dx, dy, r);
    if (typed) begin
      r.color  = want_color;
      r.status = want_status;
    end
    replies_due.push_back(r);
  endtask

  // Drops valid and waits until every reply is back and the engine takes
  // requests again, so that a scroll or clear walk has finished.
  task automatic settle;
    @(negedge clk);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0 || in_tready !== 1'b1);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WIDTH:  shadow_width  = value[8:0];
      CFG_HEIGHT: shadow_height = value[8:0];
      CFG_FILL:   shadow_fill   = value;
      default: ;
    endcase
  endtask

  function automatic plan_row_t reg_row(input cfg_idx_t idx, input logic [31:0] value);
    plan_row_t row;
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = value;
    row.typed   = 1'b0;
    return row;
  endfunction

  function automatic plan_row_t req_row(input req_t kind, input logic [7:0] px,
                                        input logic [7:0] py, input logic [31:0] color,
                                        input logic [9:0] dx, input logic [9:0] dy);
    plan_row_t row;
    row.is_reg      = 1'b0;
    row.reg_idx     = CFG_SPARE;
    row.reg_val     = '0;
    row.kind        = kind;
    row.px          = px;
    row.py          = py;
    row.color       = color;
    row.dx          = dx;
    row.dy          = dy;
    row.typed       = 1'b0;
    row.want_color  = '0;
    row.want_status = 1'b0;
    return row;
  endfunction

  function automatic plan_row_t fixed_row(input req_t kind, input logic [7:0] px,
                                          input logic [7:0] py, input logic [31:0] color,
                                          input logic [9:0] dx, input logic [9:0] dy,
                                          input logic [31:0] want_color,
                                          input logic want_status);
    plan_row_t row;
    row             = req_row(kind, px, py, color, dx, dy);
    row.typed       = 1'b1;
    row.want_color  = want_color;
    row.want_status = want_status;
    return row;
  endfunction

  // Result side: takes one reply per loop after its own random gap, and once on
  // request holds off for a long stretch so the engine backs up into its input.
  initial begin : result_sink
    int gap;
    reply_t want;
    forever begin
      gap = draw_gap(rx_idle_on);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        gap = LONG_HOLD;
      end
      @(negedge clk);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      if (replies_due.size() == 0) begin
        report_mismatch("reply with no request pending", out_tdata[31:0], '0);
      end else begin
        want = replies_due.pop_front();
        if (out_tdata[31:0] !== want.color)
          report_mismatch({want.kind.name(), " read_color"}, out_tdata[31:0], want.color);
        if (out_tdata[32] !== want.status)
          report_mismatch({want.kind.name(), " status"}, 32'(out_tdata[32]),
                          32'(want.status));
      end
    end
  end

  // Ends the run if neither channel completes a handshake for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    plan_row_t   plan[$];
    logic [15:0] recent_spots[$];
    logic [15:0] spot;
    logic [7:0]  px, py;
    logic [31:0] wv;
    req_t        kind;
    int          p, n, roll, w, h, aw, ah, clears_left;
    bit          scroll_ok;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. The store reads back zero after reset, the corners are
    // reachable at full size, and an oversized width still acts as full size.
    plan.push_back(fixed_row(REQ_READ,  8'd0,   8'd0,   32'h0,         10'd0, 10'd0,
                             32'h0, 1'b0));
    plan.push_back(fixed_row(REQ_WRITE, 8'd255, 8'd255, 32'hFFFF_FFFF, 10'd0, 10'd0,
                             32'h0, 1'b0));
    plan.push_back(fixed_row(REQ_READ,  8'd255, 8'd255, 32'h0,         10'd0, 10'd0,
                             32'hFFFF_FFFF, 1'b0));
    plan.push_back(fixed_row(REQ_WRITE, 8'd0,   8'd0,   32'hA5A5_5A5A, 10'd0, 10'd0,
                             32'h0, 1'b0));
    plan.push_back(reg_row(CFG_WIDTH, 32'hFFFF_FF2C));
    plan.push_back(fixed_row(REQ_READ,  8'd255, 8'd0,   32'h0,         10'd0, 10'd0,
                             32'h0, 1'b0));
    // Shrink to 16x8: points just past the edge are refused.
    plan.push_back(reg_row(CFG_WIDTH, 32'd16));
    plan.push_back(reg_row(CFG_HEIGHT, 32'd8));
    plan.push_back(fixed_row(REQ_WRITE, 8'd16,  8'd0,   32'h0000_0001, 10'd0, 10'd0,
                             32'h0, 1'b1));
    plan.push_back(fixed_row(REQ_WRITE, 8'd15,  8'd7,   32'h1234_5678, 10'd0, 10'd0,
                             32'h0, 1'b0));
    // A new fill color does not repaint what is already stored.
    plan.push_back(reg_row(CFG_FILL, 32'hDEAD_BEEF));
    plan.push_back(fixed_row(REQ_READ,  8'd15,  8'd7,   32'h0,         10'd0, 10'd0,
                             32'h1234_5678, 1'b0));
    // Scroll down-right by one: the top-left corner takes the fill color and the
    // old corner pixel shows up one step in.
    plan.push_back(fixed_row(REQ_SCROLL, 8'd0,  8'd0,   32'h0,         10'd1, 10'd1,
                             32'h0, 1'b0));
    plan.push_back(fixed_row(REQ_READ,  8'd0,   8'd0,   32'h0,         10'd0, 10'd0,
                             32'hDEAD_BEEF, 1'b0));
    plan.push_back(fixed_row(REQ_READ,  8'd1,   8'd1,   32'h0,         10'd0, 10'd0,
                             32'hA5A5_5A5A, 1'b0));
    // Shifts at or beyond the active size wipe the window.
    plan.push_back(fixed_row(REQ_SCROLL, 8'd0,  8'd0,   32'h0,         10'h300, 10'd0,
                             32'h0, 1'b0));
    plan.push_back(fixed_row(REQ_READ,  8'd3,   8'd3,   32'h0,         10'd0, 10'd0,
                             32'hDEAD_BEEF, 1'b0));
    plan.push_back(fixed_row(REQ_SCROLL, 8'd0,  8'd0,   32'h0,         10'h200, 10'h1FF,
                             32'h0, 1'b0));
    // The spare register index is ignored, so the width is still 16.
    plan.push_back(reg_row(CFG_SPARE, 32'h0000_0001));
    plan.push_back(fixed_row(REQ_READ,  8'd16,  8'd0,   32'h0,         10'd0, 10'd0,
                             32'h0, 1'b1));
    // An empty window refuses every point and a scroll there is a no-op.
    plan.push_back(reg_row(CFG_WIDTH, 32'd0));
    plan.push_back(fixed_row(REQ_WRITE, 8'd0,   8'd0,   32'h0000_0007, 10'd0, 10'd0,
                             32'h0, 1'b1));
    plan.push_back(fixed_row(REQ_READ,  8'd0,   8'd0,   32'h0,         10'd0, 10'd0,
                             32'h0, 1'b1));
    plan.push_back(fixed_row(REQ_SCROLL, 8'd0,  8'd0,   32'h0,         10'd5, 10'd5,
                             32'h0, 1'b0));
    // Back to full size: the far corner kept its color through every scroll.
    plan.push_back(reg_row(CFG_WIDTH, 32'h0000_01FF));
    plan.push_back(reg_row(CFG_HEIGHT, 32'd256));
    plan.push_back(fixed_row(REQ_READ,  8'd255, 8'd255, 32'h0,         10'd0, 10'd0,
                             32'hFFFF_FFFF, 1'b0));
    plan.push_back(fixed_row(REQ_READ,  8'd0,   8'd0,   32'h0,         10'd0, 10'd0,
                             32'hDEAD_BEEF, 1'b0));
    // A clear repaints the whole store with the current fill color.
    plan.push_back(reg_row(CFG_FILL, 32'h0102_0304));
    plan.push_back(fixed_row(REQ_CLEAR, 8'd0,   8'd0,   32'h0,         10'd0, 10'd0,
                             32'h0, 1'b0));
    plan.push_back(fixed_row(REQ_READ,  8'd255, 8'd255, 32'h0,         10'd0, 10'd0,
                             32'h0102_0304, 1'b0));
    // One full-size scroll up and to the right, then look where the pixel went.
    plan.push_back(fixed_row(REQ_WRITE, 8'd128, 8'd200, 32'h8000_0001, 10'd0, 10'd0,
                             32'h0, 1'b0));
    plan.push_back(req_row(REQ_SCROLL, 8'd0,   8'd0,   32'h0,         10'd3, 10'h3FE));
    plan.push_back(req_row(REQ_READ,   8'd131, 8'd198, 32'h0,         10'd0, 10'd0));

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_request(plan[i].kind, plan[i].px, plan[i].py, plan[i].color, plan[i].dx,
                     plan[i].dy, plan[i].typed, plan[i].want_color, plan[i].want_status);
      end
    end

    // Random phases, each with its own window size and fill color. Scrolls run only
    // in windows of at most 4096 pixels so they stay cheap; the full-size phase does no
    // scrolls, and at most two clears are spent across the whole run.
    clears_left = 2;
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin w = 16;  h = 16;  end
        1:       begin w = 1;   h = 1;   end
        2:       begin w = 256; h = 1;   end
        3:       begin w = 1;   h = 256; end
        4:       begin w = 8;   h = 8;   end
        5:       begin w = 0;   h = 12;  end
        6:       begin w = 20;  h = 0;   end
        7:       begin w = 511; h = 4;   end
        8:       begin w = 256; h = 256; end
        9:       begin w = 32;  h = 24;  end
        10:      begin w = 3;   h = 40;  end
        default: begin w = $urandom_range(1, 24); h = $urandom_range(1, 24); end
      endcase
      settle();
      // Bits above the nine that the size registers keep carry junk now and then.
      wv = {($urandom_range(0, 1) != 0) ? 23'($urandom) : 23'd0, 9'(w)};
      write_reg(CFG_WIDTH, wv);
      wv = {($urandom_range(0, 1) != 0) ? 23'($urandom) : 23'd0, 9'(h)};
      write_reg(CFG_HEIGHT, wv);
      case (p)
        1:       write_reg(CFG_FILL, 32'h0);
        2:       write_reg(CFG_FILL, 32'hFFFF_FFFF);
        default: write_reg(CFG_FILL, $urandom);
      endcase
      aw = active_span(shadow_width, MAX_WIDTH);
      ah = active_span(shadow_height, MAX_HEIGHT);
      scroll_ok = (aw * ah <= 4096);
      recent_spots.delete();

      // Some phases run without gaps on one side or both; in the pressure phase
      // the sender never pauses while the result side holds off for a long time.
      tx_idle_on = (p % 3 != 1) && (p != 4);
      rx_idle_on = (p % 4 != 2);
      if (p == 4) hold_off_pending = 1'b1;

      for (n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (clears_left > 0 && roll == 0) begin
          kind = REQ_CLEAR;
          clears_left--;
        end else if (scroll_ok && roll < 14) begin
          kind = REQ_SCROLL;
        end else if (roll < 57) begin
          kind = REQ_WRITE;
        end else begin
          kind = REQ_READ;
        end
        // Reads often revisit recently written points so that stored colors,
        // including those moved by scrolls, actually get read back.
        if (kind == REQ_READ && recent_spots.size() != 0 && $urandom_range(0, 1) != 0) begin
          spot = recent_spots[$urandom_range(0, recent_spots.size() - 1)];
          px = spot[7:0];
          py = spot[15:8];
        end else begin
          px = pick_coord(aw);
          py = pick_coord(ah);
        end
        if (kind == REQ_WRITE) begin
          recent_spots.push_back({py, px});
          if (recent_spots.size() > 16) void'(recent_spots.pop_front());
        end
        send_request(kind, px, py, $urandom, pick_shift(aw), pick_shift(ah),
                     1'b0, 32'h0, 1'b0);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== framebuffer_scroll_engine.f =====
design/fbse_pkg.sv
design/fbse_pixel_ram.sv
design/fbse_walker.sv
design/framebuffer_scroll_engine.sv
test/tb_top.sv
